// ===== rtl/lfo_pkg.sv =====
// Shared types and constants for the low-frequency oscillator.
// Used by every module under rtl/; depends on nothing else.
package lfo_pkg;

    localparam int STEP_W   = 31;   // phase step, Q0.32 with the top bit always zero
    localparam int VAL_W    = 16;   // range bounds and output value
    localparam int WAVE_W   = 17;   // Q1.15 waveform, +1 = 32768
    localparam int SPAN_W   = 17;   // range_high - range_low
    localparam int FRAC_W   = 32;   // Q0.32 phase fraction
    localparam int SEL_W    = 3;
    localparam int MAG_W    = 16;   // quarter sine magnitude, up to 32768
    localparam int S_DATA_W = 64;
    localparam int M_DATA_W = 16;

    localparam logic [SEL_W-1:0] WAVE_SINE     = 3'd0;
    localparam logic [SEL_W-1:0] WAVE_TRIANGLE = 3'd1;
    localparam logic [SEL_W-1:0] WAVE_SAW      = 3'd2;
    localparam logic [SEL_W-1:0] WAVE_INV_SAW  = 3'd3;
    localparam logic [SEL_W-1:0] WAVE_SQUARE   = 3'd4;
    localparam logic [SEL_W-1:0] WAVE_SLOPED   = 3'd5;

    // Triangle breakpoints
    localparam logic [FRAC_W-1:0] TRI_RISE_END = 32'h4000_0000;
    localparam logic [FRAC_W-1:0] TRI_FALL_END = 32'hC000_0000;

    // Sloped square breakpoints: 0.02, 0.48, 0.52, 0.98 of a cycle
    localparam logic [FRAC_W-1:0] SLOPE_TH_A = 32'd85899346;
    localparam logic [FRAC_W-1:0] SLOPE_TH_B = 32'd2061584302;
    localparam logic [FRAC_W-1:0] SLOPE_TH_C = 32'd2233382994;
    localparam logic [FRAC_W-1:0] SLOPE_TH_D = 32'd4209067950;

    // pi/2 in Q2.30 for building the sine table
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef logic signed [WAVE_W-1:0] wave_t;

    // Payload handed from the waveform stage to the range mapper
    typedef struct packed {
        logic signed [WAVE_W-1:0] wave;
        logic signed [VAL_W-1:0]  range_low;
        logic signed [SPAN_W-1:0] range_span;
    } map_in_t;

endpackage

// ===== rtl/lfo_phase.sv =====
// Phase accumulator: wrapping PHASE_BITS register, restart, Q0.32 phase and sine address.
// Depends on lfo_pkg.
module lfo_phase
    import lfo_pkg::*;
#(
    parameter int PHASE_BITS      = 32,
    parameter int SINE_TABLE_BITS = 10
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       advance,
    input  logic [STEP_W-1:0]          phase_step,
    input  logic                       restart,
    output logic [FRAC_W-1:0]          phase_frac,
    output logic [SINE_TABLE_BITS:0]   sine_addr
);

    localparam logic [SINE_TABLE_BITS:0] QTAB_N = {1'b1, {SINE_TABLE_BITS{1'b0}}};

    logic [PHASE_BITS-1:0]        acc_reg;
    logic [PHASE_BITS-1:0]        acc_next;
    logic [PHASE_BITS-1:0]        acc_base;
    logic [PHASE_BITS-1:0]        step_scaled;
    logic [PHASE_BITS+31:0]       step_wide;
    logic [PHASE_BITS+31:0]       acc_wide;
    logic [SINE_TABLE_BITS-1:0]   sine_idx;

    // Rescale the Q0.32 step to the accumulator width
    assign step_wide   = {{1'b0, phase_step}, {PHASE_BITS{1'b0}}};
    assign step_scaled = step_wide[PHASE_BITS+31 -: PHASE_BITS];

    assign acc_base = restart ? '0 : acc_reg;
    assign acc_next = acc_base + step_scaled;

    // Top 32 bits of the accumulator, zero-filled when it is narrower
    assign acc_wide   = {acc_next, 32'd0};
    assign phase_frac = acc_wide[PHASE_BITS+31 -: FRAC_W];

    // Mirror the index in the second and fourth quadrants
    assign sine_idx  = phase_frac[29 -: SINE_TABLE_BITS];
    assign sine_addr = phase_frac[30] ? (QTAB_N - {1'b0, sine_idx}) : {1'b0, sine_idx};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else if (advance)
        begin
            acc_reg <= acc_next;
        end
    end

endmodule

// ===== rtl/lfo_sine_rom.sv =====
// Quarter-wave sine ROM with registered read, built at elaboration.
// Depends on lfo_pkg.
module lfo_sine_rom
    import lfo_pkg::*;
#(
    parameter int SINE_TABLE_BITS = 10
)
(
    input  logic                     clk,
    input  logic                     en,
    input  logic [SINE_TABLE_BITS:0] addr,
    output logic [MAG_W-1:0]         data
);

    localparam int ENTRIES  = (1 << SINE_TABLE_BITS) + 1;
    localparam int ROM_BITS = ENTRIES * MAG_W;

    // round(32768*sin(pi/2*k/N)) by an eight-term integer series
    function automatic logic [MAG_W-1:0] sine_entry(input logic [SINE_TABLE_BITS:0] k);
        logic [63:0] x;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] r;
        logic        neg;
        int          n;
        x   = (HALF_PI_Q30 * 64'(k)) >> SINE_TABLE_BITS;
        t   = x;
        s   = x;
        neg = 1'b0;
        for (n = 1; n <= 7; n++)
        begin
            t = (t * x) >> 30;
            t = (t * x) >> 30;
            case (n)
                1:       t = t / 6;
                2:       t = t / 20;
                3:       t = t / 42;
                4:       t = t / 72;
                5:       t = t / 110;
                6:       t = t / 156;
                default: t = t / 210;
            endcase
            if (n % 2 == 1)
            begin
                if (neg)
                begin
                    s = s + t;
                end
                else if (t > s)
                begin
                    s   = t - s;
                    neg = 1'b1;
                end
                else
                begin
                    s = s - t;
                end
            end
            else
            begin
                if (neg)
                begin
                    if (t >= s)
                    begin
                        s   = t - s;
                        neg = 1'b0;
                    end
                    else
                    begin
                        s = s - t;
                    end
                end
                else
                begin
                    s = s + t;
                end
            end
        end
        if (neg)
        begin
            s = 64'd0;
        end
        r = (s + 64'd16384) >> 15;
        if (r > 64'd32768)
        begin
            r = 64'd32768;
        end
        return r[MAG_W-1:0];
    endfunction

    function automatic logic [ROM_BITS-1:0] build_table();
        logic [ROM_BITS-1:0] tbl;
        int                  k;
        tbl = '0;
        for (k = 0; k < ENTRIES; k++)
        begin
            tbl[k*MAG_W +: MAG_W] = sine_entry((SINE_TABLE_BITS+1)'(k));
        end
        return tbl;
    endfunction

    localparam logic [ROM_BITS-1:0] SINE_ROM = build_table();

    logic [MAG_W-1:0] data_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= SINE_ROM[addr*MAG_W +: MAG_W];
        end
    end

    assign data = data_reg;

endmodule

// ===== rtl/lfo_wave.sv =====
// Waveform shaper: Q0.32 phase and quarter-sine magnitude to a Q1.15 value.
// Depends on lfo_pkg.
module lfo_wave
    import lfo_pkg::*;
(
    input  logic [SEL_W-1:0]  wave_sel,
    input  logic [FRAC_W-1:0] phase_frac,
    input  logic [MAG_W-1:0]  sine_mag,
    output wave_t             wave
);

    logic [16:0]        p15;
    logic [15:0]        p16;
    logic signed [18:0] tri_w;
    logic signed [17:0] saw_w;
    logic signed [17:0] sine_w;
    logic [37:0]        p50;
    logic signed [39:0] slope_up;
    logic signed [39:0] slope_down;
    logic signed [39:0] slope_end;
    logic signed [22:0] slope_w;
    logic signed [22:0] raw;

    assign p15 = phase_frac[31:15];
    assign p16 = phase_frac[31:16];
    assign p50 = 38'(phase_frac) * 38'd50;

    always_comb
    begin
        if (phase_frac <= TRI_RISE_END)
        begin
            tri_w = $signed({2'b00, p15});
        end
        else if (phase_frac < TRI_FALL_END)
        begin
            tri_w = 19'sd65536 - $signed({2'b00, p15});
        end
        else
        begin
            tri_w = $signed({2'b00, p15}) - 19'sd131072;
        end
    end

    assign saw_w  = phase_frac[31] ? ($signed({2'b00, p16}) - 18'sd65536)
                                   : $signed({2'b00, p16});
    assign sine_w = phase_frac[31] ? -$signed({2'b00, sine_mag}) : $signed({2'b00, sine_mag});

    // Sloped square edges, floored to Q1.15
    assign slope_up   = $signed({2'b00, p50});
    assign slope_down = 40'sd107374182400 - slope_up;
    assign slope_end  = slope_up - 40'sd214748364800;

    always_comb
    begin
        if (phase_frac < SLOPE_TH_A)
        begin
            slope_w = 23'(slope_up >>> 17);
        end
        else if (phase_frac < SLOPE_TH_B)
        begin
            slope_w = 23'sd32768;
        end
        else if (phase_frac < SLOPE_TH_C)
        begin
            slope_w = 23'(slope_down >>> 17);
        end
        else if (phase_frac < SLOPE_TH_D)
        begin
            slope_w = -23'sd32768;
        end
        else
        begin
            slope_w = 23'(slope_end >>> 17);
        end
    end

    always_comb
    begin
        case (wave_sel)
            WAVE_TRIANGLE: raw = 23'(tri_w);
            WAVE_SAW:      raw = 23'(saw_w);
            WAVE_INV_SAW:  raw = -23'(saw_w);
            WAVE_SQUARE:   raw = phase_frac[31] ? -23'sd32768 : 23'sd32768;
            WAVE_SLOPED:   raw = slope_w;
            default:       raw = 23'(sine_w);
        endcase
    end

    // Clamp to the closed span -1..+1
    always_comb
    begin
        if (raw > 23'sd32768)
        begin
            wave = 17'sd32768;
        end
        else if (raw < -23'sd32768)
        begin
            wave = -17'sd32768;
        end
        else
        begin
            wave = raw[WAVE_W-1:0];
        end
    end

endmodule

// ===== rtl/lfo_map.sv =====
// Range mapper: scales a Q1.15 value from -1..+1 onto range_low..range_high, saturated.
// Depends on lfo_pkg.
module lfo_map
    import lfo_pkg::*;
(
    input  map_in_t                 map_in,
    output logic signed [VAL_W-1:0] lfo_value
);

    logic [16:0]        offs;
    logic signed [34:0] prod;
    logic signed [34:0] prod_rnd;
    logic signed [18:0] scaled;
    logic signed [19:0] sum;

    // 0..65536 after lifting by one
    assign offs     = 17'($signed(map_in.wave) + 17'sd32768);
    assign prod     = $signed({1'b0, offs}) * $signed(map_in.range_span);
    assign prod_rnd = prod + 35'sd32768;
    assign scaled   = prod_rnd[34:16];
    assign sum      = 20'($signed(map_in.range_low)) + 20'(scaled);

    always_comb
    begin
        if (sum > 20'sd32767)
        begin
            lfo_value = 16'sh7FFF;
        end
        else if (sum < -20'sd32768)
        begin
            lfo_value = 16'sh8000;
        end
        else
        begin
            lfo_value = sum[VAL_W-1:0];
        end
    end

endmodule

// ===== rtl/lfo_waveform_generator.sv =====
// Top level of the low-frequency oscillator: three-stage pipeline with stream handshakes.
// Depends on lfo_pkg, lfo_phase, lfo_sine_rom, lfo_wave and lfo_map.
//
//   Channel   Direction  Beat contents
//   --------  ---------  ---------------------------------------------------------
//   s_*       in         tdata: phase_step[30:0], range_low[46:31], range_high[62:47]
//                        tuser: restart
//   m_*       out        tdata: lfo_value[15:0]
//   cfg_*     in         cfg_data: waveform_select[2:0]
//
// One beat in and one beat out per cycle when both sides flow.
// The accumulator add and the sine ROM address feed the first register, the waveform
// shaping the second and the range multiply the output register.
// Each stage holds while the stage after it is full and stalled, so a waiting result
// does not block the input until all three stages are full.
// rst_n clears the phase, the waveform select (sine) and all valid flags.
module lfo_waveform_generator
    import lfo_pkg::*;
#(
    parameter int PHASE_BITS      = 32,
    parameter int SINE_TABLE_BITS = 10
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // phase_step[30:0], range_low, range_high, zero pad
    input  logic [0:0]          s_tuser,   // restart
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // lfo_value
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [SEL_W-1:0]    cfg_data   // waveform_select
);

    logic                       accept;
    logic                       en1;
    logic                       en2;
    logic                       en3;

    logic [STEP_W-1:0]          in_step;
    logic signed [VAL_W-1:0]    in_low;
    logic signed [VAL_W-1:0]    in_high;

    logic [FRAC_W-1:0]          phase_frac;
    logic [SINE_TABLE_BITS:0]   sine_addr;
    logic [MAG_W-1:0]           sine_mag;
    wave_t                      wave;
    map_in_t                    map_next;
    logic signed [VAL_W-1:0]    value_next;

    logic [SEL_W-1:0]           wave_sel_reg;
    logic                       v1_reg;
    logic [FRAC_W-1:0]          frac1_reg;
    logic signed [VAL_W-1:0]    low1_reg;
    logic signed [VAL_W-1:0]    high1_reg;
    logic                       v2_reg;
    map_in_t                    map_reg;
    logic                       out_valid_reg;
    logic signed [VAL_W-1:0]    value_reg;

    assign in_step = s_tdata[30:0];
    assign in_low  = s_tdata[46:31];
    assign in_high = s_tdata[62:47];

    // A stage loads when it is empty or its contents move on this cycle
    assign en3      = !out_valid_reg || m_tready;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign s_tready = en1;
    assign accept   = s_tvalid && en1;

    // Configuration is taken at any time
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wave_sel_reg <= WAVE_SINE;
        end
        else if (cfg_valid)
        begin
            wave_sel_reg <= cfg_data;
        end
    end

    // Stage 1: advance the phase and address the sine ROM
    lfo_phase #(
        .PHASE_BITS      (PHASE_BITS),
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_phase (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (accept),
        .phase_step (in_step),
        .restart    (s_tuser[0]),
        .phase_frac (phase_frac),
        .sine_addr  (sine_addr)
    );

    lfo_sine_rom #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_sine_rom (
        .clk  (clk),
        .en   (en1),
        .addr (sine_addr),
        .data (sine_mag)
    );

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            frac1_reg <= phase_frac;
            low1_reg  <= in_low;
            high1_reg <= in_high;
        end
    end

    // Stage 2: shape the waveform and form the range span
    lfo_wave u_wave (
        .wave_sel   (wave_sel_reg),
        .phase_frac (frac1_reg),
        .sine_mag   (sine_mag),
        .wave       (wave)
    );

    assign map_next.wave       = wave;
    assign map_next.range_low  = low1_reg;
    assign map_next.range_span = 17'(high1_reg) - 17'(low1_reg);

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            map_reg <= map_next;
        end
    end

    // Stage 3: map onto the range and saturate
    lfo_map u_map (
        .map_in    (map_reg),
        .lfo_value (value_next)
    );

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            value_reg <= value_next;
        end
    end

    // Valid flags follow their payloads down the pipe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= s_tvalid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                out_valid_reg <= v2_reg;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = value_reg;

endmodule

// ===== dv/lfo_waveform_generator_tb.sv =====
// Self-checking testbench for lfo_waveform_generator: stream beats in, checked values out.
// Holds its own bit-exact oscillator predictor in a small scoreboard class.
// Depends on lfo_pkg and the RTL under rtl/.
module lfo_waveform_generator_tb;
    import lfo_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PIPE_DEPTH   = 3;        // registers between input beat and output beat
    localparam int PRESS_CYCLES = 200;      // long back-pressure stretch on the output
    localparam int RANDOM_ITEMS = 1450;
    localparam int QTAB_N       = 1024;     // quarter sine steps; QTAB_N+1 entries (SINE_TABLE_BITS = 10)
    localparam longint TIMEOUT_NS = 20_000_000;

    // selector codes the block does not define; both fall back to sine
    localparam logic [SEL_W-1:0] WAVE_SPARE_LO = 3'd6;
    localparam logic [SEL_W-1:0] WAVE_SPARE_HI = 3'd7;

    // pi/2 in Q2.30 and the sloped-square corners 0.02, 0.48, 0.52, 0.98 in Q0.32
    localparam longint HALF_PI_Q2_30 = 64'd1686629713;
    localparam longint CORNER_RISE   = 64'd85899346;
    localparam longint CORNER_HIGH   = 64'd2061584302;
    localparam longint CORNER_FALL   = 64'd2233382994;
    localparam longint CORNER_LOW    = 64'd4209067950;

    typedef struct {
        logic [STEP_W-1:0]       step;
        logic signed [VAL_W-1:0] range_low;
        logic signed [VAL_W-1:0] range_high;
        logic                    restart;
    } lfo_beat_t;

    // Scoreboard: tracks phase and waveform select, queues predicted values
    class lfo_scoreboard;
        logic [FRAC_W-1:0]       phase;
        logic [SEL_W-1:0]        wave_sel;
        longint                  quarter_mag[0:QTAB_N];
        logic signed [VAL_W-1:0] expected_values[$];
        int                      n_errors;
        int                      n_checked;

        function new();
            longint unsigned x;
            longint unsigned t;
            longint          s;
            phase     = '0;
            wave_sel  = WAVE_SINE;
            n_errors  = 0;
            n_checked = 0;
            // quarter sine by integer Taylor series, rounded to Q1.15
            for (int k = 0; k <= QTAB_N; k++)
            begin
                x = (HALF_PI_Q2_30 * k) / QTAB_N;
                t = x;
                s = x;
                for (int n = 1; n <= 7; n++)
                begin
                    t = (t * x) >> 30;
                    t = (t * x) >> 30;
                    t = t / ((2 * n) * (2 * n + 1));
                    if (n % 2 == 1)
                        s = s - longint'(t);
                    else
                        s = s + longint'(t);
                end
                if (s < 0)
                    s = 0;
                s = (s + (1 << 14)) / (1 << 15);
                quarter_mag[k] = (s > 32768) ? 32768 : s;
            end
        endfunction

        function void set_wave(logic [SEL_W-1:0] sel);
            wave_sel = sel;
        endfunction

        function int pending();
            return expected_values.size();
        endfunction

        // waveform value in Q1.15 for phase fraction p, clamped to +-1
        function longint shape_wave(logic [FRAC_W-1:0] p);
            longint pp;
            longint w;
            longint v;
            pp = p;
            case (wave_sel)
                WAVE_TRIANGLE:
                    if (pp <= 64'h4000_0000)
                        w = pp >> 15;
                    else if (pp < 64'hC000_0000)
                        w = 65536 - (pp >> 15);
                    else
                        w = (pp >> 15) - 131072;
                WAVE_SAW:
                    w = (pp < 64'h8000_0000) ? (pp >> 16) : (pp >> 16) - 65536;
                WAVE_INV_SAW:
                    w = (pp < 64'h8000_0000) ? -(pp >> 16) : 65536 - (pp >> 16);
                WAVE_SQUARE:
                    w = (pp < 64'h8000_0000) ? 32768 : -32768;
                WAVE_SLOPED:
                    if (pp < CORNER_RISE)
                        w = (pp * 50) >>> 17;
                    else if (pp < CORNER_HIGH)
                        w = 32768;
                    else if (pp < CORNER_FALL)
                        w = ((longint'(25) << 32) - pp * 50) >>> 17;
                    else if (pp < CORNER_LOW)
                        w = -32768;
                    else
                        w = (pp * 50 - (longint'(50) << 32)) >>> 17;
                default:
                begin
                    // mirror the index in quadrants two and four, negate in the second half of the cycle
                    v = p[30] ? quarter_mag[QTAB_N - p[29:20]] : quarter_mag[p[29:20]];
                    w = p[31] ? -v : v;
                end
            endcase
            if (w > 32768)
                w = 32768;
            if (w < -32768)
                w = -32768;
            return w;
        endfunction

        // map -1..+1 onto range_low..range_high with round-half-up rounding, then saturate
        function logic signed [VAL_W-1:0] map_to_range(longint w, longint lo, longint hi);
            longint prod;
            longint y;
            prod = (w + 32768) * (hi - lo) + 32768;
            y = lo + (prod >>> 16);
            if (y > 32767)
                y = 32767;
            if (y < -32768)
                y = -32768;
            return y[VAL_W-1:0];
        endfunction

        function void note_input(lfo_beat_t beat);
            if (beat.restart)
                phase = '0;
            phase = phase + {1'b0, beat.step};
            expected_values.push_back(map_to_range(shape_wave(phase),
                                                   beat.range_low, beat.range_high));
        endfunction

        function void check_result(logic [M_DATA_W-1:0] actual);
            logic signed [VAL_W-1:0] want;
            if (expected_values.size() == 0)
            begin
                n_errors++;
                if (n_errors <= 10)
                    $display("ERROR: output beat %0d with no value pending", $signed(actual));
                return;
            end
            want = expected_values.pop_front();
            n_checked++;
            if (actual !== want)
            begin
                n_errors++;
                if (n_errors <= 10)
                    $display("ERROR: lfo_value beat %0d expected %0d got %0d",
                             n_checked, want, $signed(actual));
            end
        endfunction

        // anything still queued at the end is a missing output
        function void close();
            if (expected_values.size() != 0)
            begin
                n_errors++;
                if (n_errors <= 10)
                    $display("ERROR: %0d output beats never arrived", expected_values.size());
            end
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;   // phase_step[30:0], range_low, range_high, zero pad
    logic [0:0]          s_tuser = '0;   // restart
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;        // lfo_value
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [SEL_W-1:0]    cfg_data = '0;  // waveform_select

    lfo_scoreboard sb = new();
    bit            src_choppy = 1'b0;    // sender inserts gaps when set

    lfo_waveform_generator u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Hard stop in case the block hangs
    initial
    begin
        #(TIMEOUT_NS);
        $display("simulation failed");
        $finish;
    end

    // Sample both stream handshakes at the rising edge; check outputs before
    // noting inputs so an input beat never matches its own edge.
    always @(posedge clk)
    begin
        lfo_beat_t beat;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
            if (s_tvalid && s_tready)
            begin
                beat.step       = s_tdata[30:0];
                beat.range_low  = s_tdata[46:31];
                beat.range_high = s_tdata[62:47];
                beat.restart    = s_tuser[0];
                sb.note_input(beat);
            end
        end
    end

    // Idle length: mostly short, now and then long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        else if (r < 92)
            return $urandom_range(4, 8);
        else
            return $urandom_range(10, 40);
    endfunction

    // Output side: alternate free-flowing and choppy stretches; once, hold off
    // for a long stretch so the pipeline fills and stalls the input.
    initial
    begin
        int  hold;
        int  run_left;
        bit  choppy;
        bit  pressed;
        hold     = 0;
        run_left = 0;
        choppy   = 1'b0;
        pressed  = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!pressed && sb.n_checked >= 300)
            begin
                pressed = 1'b1;
                hold    = PRESS_CYCLES;
            end
            if (run_left == 0)
            begin
                choppy   = ($urandom_range(0, 2) != 0);
                run_left = $urandom_range(50, 300);
            end
            run_left--;
            if (hold == 0 && choppy && $urandom_range(0, 3) == 0)
                hold = gap_len();
            if (hold > 0)
            begin
                m_tready <= 1'b0;
                hold--;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Offer one beat, hold it until accepted, then, if the sender is choppy, sometimes idle for a random gap
    task automatic send_beat(lfo_beat_t beat);
        int gap;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, beat.range_high, beat.range_low, beat.step};
        s_tuser  <= beat.restart;
        do
            @(posedge clk);
        while (!s_tready);
        gap = (src_choppy && $urandom_range(0, 1) == 0) ? gap_len() : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // Drop valid and wait until every predicted value has come out
    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 2) @(posedge clk);
    endtask

    // Write waveform_select; only called with the pipeline empty
    task automatic write_wave(logic [SEL_W-1:0] sel);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= sel;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_wave(sel);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic lfo_beat_t make_beat(logic [STEP_W-1:0] step, int lo, int hi,
                                            bit restart);
        lfo_beat_t beat;
        beat.step       = step;
        beat.range_low  = lo[VAL_W-1:0];
        beat.range_high = hi[VAL_W-1:0];
        beat.restart    = restart;
        return beat;
    endfunction

    // Random beat: mostly slow LFO steps, some coarse and full-width ones, and
    // a few picks right on the waveform corners, often with a restart.
    function automatic lfo_beat_t random_beat();
        lfo_beat_t beat;
        int        r;
        int        corner;
        r = $urandom_range(0, 99);
        beat.restart = ($urandom_range(0, 19) == 0);
        if (r < 45)
            beat.step = STEP_W'($urandom_range(0, 1 << 22));
        else if (r < 65)
            beat.step = STEP_W'($urandom_range(0, 1 << 28));
        else if (r < 90)
            beat.step = STEP_W'($urandom);
        else
        begin
            corner = $urandom_range(0, 7);
            case (corner)
                0: beat.step = '0;
                1: beat.step = 31'h7FFF_FFFF;
                2: beat.step = 31'h4000_0000;
                3: beat.step = 31'h3FFF_FFFF;
                4: beat.step = CORNER_RISE[30:0] - 31'd1;
                5: beat.step = CORNER_RISE[30:0];
                6: beat.step = CORNER_HIGH[30:0] - 31'd1;
                default: beat.step = CORNER_HIGH[30:0];
            endcase
            beat.restart = ($urandom_range(0, 1) != 0);
        end
        r = $urandom_range(0, 99);
        if (r < 70)
        begin
            beat.range_low  = VAL_W'($urandom);
            beat.range_high = VAL_W'($urandom);
        end
        else if (r < 85)
        begin
            beat.range_low  = ($urandom_range(0, 1) != 0) ? 16'sh8000 : 16'sh7FFF;
            beat.range_high = ($urandom_range(0, 1) != 0) ? 16'sh8000 : 16'sh7FFF;
        end
        else
        begin
            beat.range_low  = VAL_W'($urandom);
            beat.range_high = beat.range_low;
        end
        return beat;
    endfunction

    initial
    begin
        logic [SEL_W-1:0] phase_waves[7];
        int               sent;
        int               count;
        logic [SEL_W-1:0] sel;

        phase_waves = '{WAVE_SINE, WAVE_SPARE_HI, WAVE_SLOPED, WAVE_TRIANGLE,
                        WAVE_SAW, WAVE_INV_SAW, WAVE_SQUARE};

        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: per selector, land exactly on the quarter point from a
        // restart, sweep a reversed full range, then wrap past one cycle.
        for (int s = 0; s < 8; s++)
        begin
            sel = SEL_W'(s);
            write_wave(sel);
            send_beat(make_beat(31'h4000_0000, -32768, 32767, 1'b1));
            send_beat(make_beat(31'h7FFF_FFFF, 32767, -32768, 1'b0));
            send_beat(make_beat(31'h7FFF_FFFF, -1000, 1000, 1'b0));
            drain();
        end

        // Random phases: fixed selector order first, then random selectors
        sent = 0;
        for (int ph = 0; sent < RANDOM_ITEMS; ph++)
        begin
            sel = (ph < 7) ? phase_waves[ph] : SEL_W'($urandom_range(0, 7));
            write_wave(sel);
            src_choppy = ($urandom_range(0, 3) != 0);
            count = $urandom_range(60, 120);
            for (int i = 0; i < count; i++)
                send_beat(random_beat());
            sent += count;
            drain();
        end

        sb.close();
        if (sb.n_errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/lfo_pkg.sv
rtl/lfo_phase.sv
rtl/lfo_sine_rom.sv
rtl/lfo_wave.sv
rtl/lfo_map.sv
rtl/lfo_waveform_generator.sv
dv/lfo_waveform_generator_tb.sv
